// ----- hw/rtl/ibbl_pkg.sv -----
// ----------------------------------------------------------------------------
// ibbl_pkg
// Shared codes and the command/status types between controller and datapath.
// ----------------------------------------------------------------------------
package ibbl_pkg;

  localparam int POS_W = 13;

  localparam logic [1:0] MODE_HDR    = 2'd0;
  localparam logic [1:0] MODE_KEY    = 2'd1;
  localparam logic [1:0] MODE_LEAF   = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;

  localparam logic [1:0] KIND_TUPLE = 2'd1;
  localparam logic [1:0] KIND_LINK  = 2'd2;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EXACT = 2'd2;

  localparam logic CFG_BRANCHING  = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_WRITE = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd2;
  localparam logic [3:0] OP_SKIP  = 4'd3;
  localparam logic [3:0] OP_ENTER = 4'd4;
  localparam logic [3:0] OP_NOKEY = 4'd5;
  localparam logic [3:0] OP_KNEXT = 4'd6;
  localparam logic [3:0] OP_KHIT  = 4'd7;
  localparam logic [3:0] OP_KEND  = 4'd8;
  localparam logic [3:0] OP_LEAF  = 4'd9;
  localparam logic [3:0] OP_LERR  = 4'd10;
  localparam logic [3:0] OP_HOP   = 4'd11;
  localparam logic [3:0] OP_CLR   = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pos_ge_nc;
    logic pos_ge_slots;
    logic leaf_oob;
    logic hdr_node;
    logic cnt_zero;
    logic key_hit;
    logic key_last;
    logic leaf_link;
    logic link_bad;
  } status_t;

endpackage

// ----- hw/rtl/ibbl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ibbl_ctrl
// Sequencer for clearing, writes and the node/key/leaf walk of a lookup.
// ----------------------------------------------------------------------------
module ibbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_mode,
  input  ibbl_pkg::status_t status,
  output ibbl_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);
  import ibbl_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_NODE = 4'd2;
  localparam logic [3:0] S_HDR  = 4'd3;
  localparam logic [3:0] S_KRD  = 4'd4;
  localparam logic [3:0] S_KCMP = 4'd5;
  localparam logic [3:0] S_LRD  = 4'd6;
  localparam logic [3:0] S_LEAF = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_LOOKUP) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_NODE;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_NODE: begin
        if (status.pos_ge_nc) begin
          cmd.op    = OP_LEAF;
          state_nxt = status.leaf_oob ? S_OUT : S_LRD;
        end else if (status.pos_ge_slots) begin
          cmd.op = OP_SKIP;
        end else begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        state_nxt = S_NODE;
        if (!status.hdr_node) begin
          cmd.op = OP_SKIP;
        end else if (status.cnt_zero) begin
          cmd.op = OP_NOKEY;
        end else begin
          cmd.op    = OP_ENTER;
          state_nxt = S_KRD;
        end
      end
      S_KRD: state_nxt = S_KCMP;
      S_KCMP: begin
        if (status.key_hit) begin
          cmd.op    = OP_KHIT;
          state_nxt = S_NODE;
        end else if (status.key_last) begin
          cmd.op    = OP_KEND;
          state_nxt = S_NODE;
        end else begin
          cmd.op    = OP_KNEXT;
          state_nxt = S_KRD;
        end
      end
      S_LRD: state_nxt = S_LEAF;
      S_LEAF: begin
        if (!status.leaf_link) begin
          state_nxt = S_OUT;
        end else if (status.link_bad) begin
          cmd.op    = OP_LERR;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_HOP;
          state_nxt = S_NODE;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ----- hw/rtl/ibbl_dp.sv -----
// ----------------------------------------------------------------------------
// ibbl_dp
// Tree store memories, configuration registers and walk registers.
// ----------------------------------------------------------------------------
module ibbl_dp #(
  parameter int NUM_BLOCKS = 16,
  parameter int NODE_SLOTS = 64,
  parameter int MAX_KEYS   = 15,
  parameter int LEAF_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ibbl_pkg::cmd_t    cmd,
  output ibbl_pkg::status_t status,
  input  logic              cfg_wr,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic [1:0]        in_mode,
  input  logic [3:0]        in_block_index,
  input  logic [5:0]        in_slot_index,
  input  logic [3:0]        in_key_index,
  input  logic [31:0]       in_key,
  input  logic              in_slot_is_node,
  input  logic [3:0]        in_key_count,
  input  logic [1:0]        in_leaf_kind,
  input  logic [7:0]        in_leaf_index,
  input  logic [31:0]       in_leaf_target,
  output logic              out_found,
  output logic [31:0]       out_tuple_position,
  output logic [3:0]        out_final_block,
  output logic [5:0]        out_final_node,
  output logic [7:0]        out_final_leaf,
  output logic [1:0]        out_match_status,
  output logic              out_error
);
  import ibbl_pkg::*;

  localparam int NODE_D = NUM_BLOCKS * NODE_SLOTS;
  localparam int KEY_D  = NODE_D * MAX_KEYS;
  localparam int LEAF_D = NUM_BLOCKS * LEAF_SLOTS;
  localparam int CLR_D  = (NODE_D > LEAF_D) ? NODE_D : LEAF_D;
  localparam int NAW    = $clog2((NODE_D > 1) ? NODE_D : 2);
  localparam int KAW    = $clog2((KEY_D > 1) ? KEY_D : 2);
  localparam int LAW    = $clog2(LEAF_D);
  localparam int CW     = $clog2(CLR_D);
  localparam int BW     = $clog2((NUM_BLOCKS > 1) ? NUM_BLOCKS : 2);
  localparam int HW     = $clog2(NUM_BLOCKS + 1);

  logic             slot_kind_mem [NODE_D];
  logic [3:0]       kcnt_mem      [NODE_D];
  logic [31:0]      key_mem       [KEY_D];
  logic [1:0]       lkind_mem     [LEAF_D];
  logic [31:0]      ltgt_mem      [LEAF_D];

  logic [4:0]       branching_r;
  logic [6:0]       node_count_r;
  logic [CW-1:0]    clr_r;
  logic [31:0]      key_r;
  logic [BW-1:0]    cur_r;
  logic [HW-1:0]    hops_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] prev_r;
  logic [POS_W-1:0] leaf_r;
  logic [1:0]       stat_r;
  logic             err_r;
  logic [4:0]       ki_r;
  logic [3:0]       cnt_r;
  logic             hdr_kind_r;
  logic [3:0]       hdr_cnt_r;
  logic [31:0]      key_rd_r;
  logic [1:0]       lkind_r;
  logic [31:0]      ltgt_r;

  logic             wr, blk_ok, slot_ok, kidx_ok, lidx_ok, clr;
  logic [NAW-1:0]   wr_node_addr, rd_node_addr;
  logic [KAW-1:0]   wr_key_addr, rd_key_addr;
  logic [LAW-1:0]   wr_leaf_addr, rd_leaf_addr;
  logic [4:0]       b_eff, ofs;
  logic [17:0]      prod;
  logic [POS_W-1:0] child, leaf_at;
  logic [3:0]       cnt_lim;

  assign wr      = (cmd.op == OP_WRITE);
  assign clr     = (cmd.op == OP_CLR);
  assign blk_ok  = 32'(in_block_index) < 32'(NUM_BLOCKS);
  assign slot_ok = 32'(in_slot_index) < 32'(NODE_SLOTS);
  assign kidx_ok = 32'(in_key_index) < 32'(MAX_KEYS);
  assign lidx_ok = 32'(in_leaf_index) < 32'(LEAF_SLOTS);

  assign wr_node_addr = NAW'(32'(in_block_index) * 32'(NODE_SLOTS) + 32'(in_slot_index));
  assign wr_key_addr  = KAW'((32'(in_block_index) * 32'(NODE_SLOTS) + 32'(in_slot_index))
                             * 32'(MAX_KEYS) + 32'(in_key_index));
  assign wr_leaf_addr = LAW'(32'(in_block_index) * 32'(LEAF_SLOTS) + 32'(in_leaf_index));
  assign rd_node_addr = NAW'(32'(cur_r) * 32'(NODE_SLOTS) + 32'(pos_r));
  assign rd_key_addr  = KAW'(32'(rd_node_addr) * 32'(MAX_KEYS) + 32'(ki_r));
  assign rd_leaf_addr = LAW'(32'(cur_r) * 32'(LEAF_SLOTS) + 32'(leaf_r));

  // node headers
  always_ff @(posedge clk) begin
    if (clr && (32'(clr_r) < 32'(NODE_D))) begin
      slot_kind_mem[NAW'(clr_r)] <= 1'b0;
      kcnt_mem[NAW'(clr_r)]      <= 4'd0;
    end else if (wr && (in_mode == MODE_HDR) && blk_ok && slot_ok) begin
      slot_kind_mem[wr_node_addr] <= in_slot_is_node;
      kcnt_mem[wr_node_addr]      <= in_key_count;
    end
    hdr_kind_r <= slot_kind_mem[rd_node_addr];
    hdr_cnt_r  <= kcnt_mem[rd_node_addr];
  end

  // keys
  always_ff @(posedge clk) begin
    if (wr && (in_mode == MODE_KEY) && blk_ok && slot_ok && kidx_ok) begin
      key_mem[wr_key_addr] <= in_key;
    end
    key_rd_r <= key_mem[rd_key_addr];
  end

  // leaves
  always_ff @(posedge clk) begin
    if (clr && (32'(clr_r) < 32'(LEAF_D))) begin
      lkind_mem[LAW'(clr_r)] <= 2'd0;
    end else if (wr && (in_mode == MODE_LEAF) && blk_ok && lidx_ok) begin
      lkind_mem[wr_leaf_addr] <= in_leaf_kind;
    end
    if (wr && (in_mode == MODE_LEAF) && blk_ok && lidx_ok) begin
      ltgt_mem[wr_leaf_addr] <= in_leaf_target;
    end
    lkind_r <= lkind_mem[rd_leaf_addr];
    ltgt_r  <= ltgt_mem[rd_leaf_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branching_r  <= 5'd2;
      node_count_r <= 7'd1;
      clr_r        <= '0;
    end else begin
      if (cfg_wr && (cfg_index == CFG_BRANCHING)) branching_r <= cfg_data[4:0];
      if (cfg_wr && (cfg_index == CFG_NODE_COUNT)) node_count_r <= cfg_data;
      if (clr) clr_r <= clr_r + CW'(1);
    end
  end

  assign b_eff   = (branching_r < 5'd2) ? 5'd2 : branching_r;
  assign prod    = {13'd0, b_eff} * {5'd0, pos_r};
  assign child   = POS_W'(prod) + POS_W'(ofs) + POS_W'(1);
  assign leaf_at = pos_r - POS_W'(node_count_r);
  assign cnt_lim = (32'(hdr_cnt_r) > 32'(MAX_KEYS)) ? 4'(MAX_KEYS) : hdr_cnt_r;

  always_comb begin
    case (cmd.op)
      OP_KHIT: ofs = ki_r;
      OP_KEND: ofs = ki_r + 5'd1;
      default: ofs = 5'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        key_r  <= in_key;
        cur_r  <= '0;
        hops_r <= '0;
        pos_r  <= '0;
        prev_r <= '0;
        stat_r <= ST_NONE;
        err_r  <= 1'b0;
      end
      OP_SKIP: pos_r <= child;
      OP_ENTER: begin
        prev_r <= pos_r;
        ki_r   <= 5'd0;
        cnt_r  <= cnt_lim;
      end
      OP_NOKEY: begin
        prev_r <= pos_r;
        stat_r <= ST_RANGE;
        pos_r  <= child;
      end
      OP_KNEXT: ki_r <= ki_r + 5'd1;
      OP_KHIT: begin
        stat_r <= (key_r == key_rd_r) ? ST_EXACT : ST_RANGE;
        pos_r  <= child;
      end
      OP_KEND: begin
        stat_r <= ST_RANGE;
        pos_r  <= child;
      end
      OP_LEAF: begin
        leaf_r <= leaf_at;
        err_r  <= status.leaf_oob;
      end
      OP_LERR: err_r <= 1'b1;
      OP_HOP: begin
        hops_r <= hops_r + HW'(1);
        cur_r  <= BW'(ltgt_r);
        pos_r  <= '0;
        prev_r <= '0;
        stat_r <= ST_NONE;
      end
      default: ;
    endcase
  end

  assign status.clr_last     = (32'(clr_r) == 32'(CLR_D - 1));
  assign status.pos_ge_nc    = (pos_r >= POS_W'(node_count_r));
  assign status.pos_ge_slots = (32'(pos_r) >= 32'(NODE_SLOTS));
  assign status.leaf_oob     = (32'(leaf_at) >= 32'(LEAF_SLOTS));
  assign status.hdr_node     = hdr_kind_r;
  assign status.cnt_zero     = (hdr_cnt_r == 4'd0);
  assign status.key_hit      = (key_r <= key_rd_r);
  assign status.key_last     = ((ki_r + 5'd1) == {1'b0, cnt_r});
  assign status.leaf_link    = (lkind_r == KIND_LINK);
  assign status.link_bad     = (32'(hops_r) >= 32'(NUM_BLOCKS)) || (ltgt_r >= 32'(NUM_BLOCKS));

  assign out_found          = !err_r && (lkind_r == KIND_TUPLE) && (stat_r == ST_EXACT);
  assign out_tuple_position = out_found ? ltgt_r : 32'd0;
  assign out_final_block    = 4'(cur_r);
  assign out_final_node     = prev_r[5:0];
  assign out_final_leaf     = leaf_r[7:0];
  assign out_match_status   = stat_r;
  assign out_error          = err_r;

endmodule

// ----- hw/rtl/implicit_btree_block_lookup.sv -----
// ----------------------------------------------------------------------------
// implicit_btree_block_lookup
// Key lookup over linked blocks of implicit b-ary search trees.
//
//   port group | handshake            | payload
//   in_        | start / busy         | mode, indices, key, header, leaf
//   out_       | out_valid (1 cycle)  | found, tuple, final position, status
//   cfg_       | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// writes complete at the accept edge; a lookup reads the header of each node
// level (not at or past NODE_SLOTS), reads and compares its keys one by one,
// reads the leaf of each block (not if out of range), then shows the result
// with busy still high; after reset a clearing pass over max(NUM_BLOCKS*NODE_SLOTS,
// NUM_BLOCKS*LEAF_SLOTS) addresses holds busy high
// out_valid is a one-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
module implicit_btree_block_lookup #(
  parameter int NUM_BLOCKS = 16,
  parameter int NODE_SLOTS = 64,
  parameter int MAX_KEYS   = 15,
  parameter int LEAF_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_block_index,
  input  logic [5:0]  in_slot_index,
  input  logic [3:0]  in_key_index,
  input  logic [31:0] in_key,
  input  logic        in_slot_is_node,
  input  logic [3:0]  in_key_count,
  input  logic [1:0]  in_leaf_kind,
  input  logic [7:0]  in_leaf_index,
  input  logic [31:0] in_leaf_target,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_tuple_position,
  output logic [3:0]  out_final_block,
  output logic [5:0]  out_final_node,
  output logic [7:0]  out_final_leaf,
  output logic [1:0]  out_match_status,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import ibbl_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ibbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ibbl_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .NODE_SLOTS (NODE_SLOTS),
    .MAX_KEYS   (MAX_KEYS),
    .LEAF_SLOTS (LEAF_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_mode),
    .in_block_index     (in_block_index),
    .in_slot_index      (in_slot_index),
    .in_key_index       (in_key_index),
    .in_key             (in_key),
    .in_slot_is_node    (in_slot_is_node),
    .in_key_count       (in_key_count),
    .in_leaf_kind       (in_leaf_kind),
    .in_leaf_index      (in_leaf_index),
    .in_leaf_target     (in_leaf_target),
    .out_found          (out_found),
    .out_tuple_position (out_tuple_position),
    .out_final_block    (out_final_block),
    .out_final_node     (out_final_node),
    .out_final_leaf     (out_final_leaf),
    .out_match_status   (out_match_status),
    .out_error          (out_error)
  );

endmodule

// ----- tb/sv/implicit_btree_block_lookup_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// implicit_btree_block_lookup_tb
// Drives header, key and leaf loads and lookups into the block search engine
// under several branching/node_count settings, predicts each lookup result
// and checks every result transfer field by field against the prediction.
// ----------------------------------------------------------------------------
module implicit_btree_block_lookup_tb;
  import ibbl_pkg::*;

  localparam int BLOCKS   = 16;
  localparam int SLOTS    = 64;
  localparam int KEYS     = 15;
  localparam int LEAVES   = 256;
  localparam int LIMIT    = 20000000;
  localparam int SETTLE   = 64;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  block_index;
    logic [5:0]  slot_index;
    logic [3:0]  key_index;
    logic [31:0] key;
    logic        slot_is_node;
    logic [3:0]  key_count;
    logic [1:0]  leaf_kind;
    logic [7:0]  leaf_index;
    logic [31:0] leaf_target;
  } item_t;

  typedef struct {
    logic        found;
    logic [31:0] tuple_position;
    logic [3:0]  final_block;
    logic [5:0]  final_node;
    logic [7:0]  final_leaf;
    logic [1:0]  match_status;
    logic        error;
  } result_t;

  class lookup_scoreboard;
    int unsigned branching;
    int unsigned node_count;
    bit          slot_node[BLOCKS*SLOTS];
    bit [3:0]    key_cnt[BLOCKS*SLOTS];
    bit [31:0]   key_mem[BLOCKS*SLOTS*KEYS];
    bit          key_set[BLOCKS*SLOTS*KEYS];
    bit [1:0]    leaf_kind_mem[BLOCKS*LEAVES];
    bit [31:0]   leaf_tgt_mem[BLOCKS*LEAVES];
    result_t     expected_q[$];
    int          errors;
    int          lookups;
    int          hits;
    int          faults;

    function new();
      branching = 2;
      node_count = 1;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void set_reg(logic idx, logic [6:0] data);
      if (idx == CFG_BRANCHING) branching = 32'(data & 7'h1f);
      else node_count = 32'(data);
    endfunction

    function bit keys_ready(int blk, int slot, int cnt);
      int n;
      for (n = 0; n < cnt && n < KEYS; n++) begin
        if (!key_set[(blk*SLOTS + slot)*KEYS + n]) return 0;
      end
      return 1;
    endfunction

    function result_t predict(logic [31:0] skey);
      result_t r;
      int unsigned cur, hops, b, pos, prev, base, cnt, j, leaf_at, stat, kind, tgt;
      bit err, hit;
      cur = 0; hops = 0; err = 0; kind = 0; tgt = 0; prev = 0; leaf_at = 0;
      stat = ST_NONE;
      b = branching < 2 ? 2 : branching;
      forever begin
        pos = 0; prev = 0; stat = ST_NONE;
        while (pos < node_count) begin
          base = cur*SLOTS + pos;
          if (pos < SLOTS && slot_node[base]) begin
            cnt = key_cnt[base] > KEYS ? KEYS : 32'(key_cnt[base]);
            prev = pos;
            hit = 0;
            for (j = 0; j < cnt; j++) begin
              if (skey <= key_mem[base*KEYS + j]) begin
                stat = (skey == key_mem[base*KEYS + j]) ? 32'(ST_EXACT) : 32'(ST_RANGE);
                hit = 1;
                break;
              end
            end
            if (!hit) stat = 32'(ST_RANGE);
            pos = b*pos + 1 + j;
          end else begin
            pos = b*pos + 1;
          end
        end
        leaf_at = pos - node_count;
        if (leaf_at >= LEAVES) begin
          err = 1;
          break;
        end
        kind = 32'(leaf_kind_mem[cur*LEAVES + leaf_at]);
        tgt = leaf_tgt_mem[cur*LEAVES + leaf_at];
        if (kind != KIND_LINK) break;
        if (hops >= BLOCKS || tgt >= BLOCKS) begin
          err = 1;
          break;
        end
        hops++;
        cur = tgt;
      end
      r.found = !err && kind == KIND_TUPLE && stat == ST_EXACT;
      r.tuple_position = r.found ? tgt : 32'd0;
      r.final_block = cur[3:0];
      r.final_node = prev[5:0];
      r.final_leaf = leaf_at[7:0];
      r.match_status = stat[1:0];
      r.error = err;
      return r;
    endfunction

    function void note_input(item_t c);
      int base;
      case (c.mode)
        MODE_HDR: begin
          base = c.block_index*SLOTS + c.slot_index;
          slot_node[base] = c.slot_is_node;
          key_cnt[base] = c.key_count;
        end
        MODE_KEY: begin
          if (c.key_index < KEYS) begin
            base = (c.block_index*SLOTS + c.slot_index)*KEYS + c.key_index;
            key_mem[base] = c.key;
            key_set[base] = 1;
          end
        end
        MODE_LEAF: begin
          base = c.block_index*LEAVES + c.leaf_index;
          leaf_kind_mem[base] = c.leaf_kind;
          leaf_tgt_mem[base] = c.leaf_target;
        end
        default: begin
          expected_q.push_back(predict(c.key));
          lookups++;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report("result with no lookup outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (exp.found) hits++;
      if (exp.error) faults++;
      if (got.found !== exp.found)
        report($sformatf("found %0d, expected %0d", got.found, exp.found));
      if (got.tuple_position !== exp.tuple_position)
        report($sformatf("tuple_position %0h, expected %0h",
                         got.tuple_position, exp.tuple_position));
      if (got.final_block !== exp.final_block)
        report($sformatf("final_block %0d, expected %0d", got.final_block, exp.final_block));
      if (got.final_node !== exp.final_node)
        report($sformatf("final_node %0d, expected %0d", got.final_node, exp.final_node));
      if (got.final_leaf !== exp.final_leaf)
        report($sformatf("final_leaf %0d, expected %0d", got.final_leaf, exp.final_leaf));
      if (got.match_status !== exp.match_status)
        report($sformatf("match_status %0d, expected %0d",
                         got.match_status, exp.match_status));
      if (got.error !== exp.error)
        report($sformatf("error %0d, expected %0d", got.error, exp.error));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_mode = 0;
  logic [3:0]  in_block_index = 0;
  logic [5:0]  in_slot_index = 0;
  logic [3:0]  in_key_index = 0;
  logic [31:0] in_key = 0;
  logic        in_slot_is_node = 0;
  logic [3:0]  in_key_count = 0;
  logic [1:0]  in_leaf_kind = 0;
  logic [7:0]  in_leaf_index = 0;
  logic [31:0] in_leaf_target = 0;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_tuple_position;
  logic [3:0]  out_final_block;
  logic [5:0]  out_final_node;
  logic [7:0]  out_final_leaf;
  logic [1:0]  out_match_status;
  logic        out_error;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [6:0]  cfg_data = 0;

  lookup_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit no_idle = 0;

  implicit_btree_block_lookup dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("implicit_btree_block_lookup test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t r;
    if (rst_n && out_valid) begin
      r.found = out_found;
      r.tuple_position = out_tuple_position;
      r.final_block = out_final_block;
      r.final_node = out_final_node;
      r.final_leaf = out_final_leaf;
      r.match_status = out_match_status;
      r.error = out_error;
      sb.check_result(r);
    end
  end

  function item_t blank_item(logic [1:0] mode);
    item_t c;
    c.mode = mode;
    c.block_index = 4'($urandom);
    c.slot_index = 6'($urandom);
    c.key_index = 4'($urandom);
    c.key = $urandom;
    c.slot_is_node = 0;
    c.key_count = 4'($urandom);
    c.leaf_kind = 2'($urandom);
    c.leaf_index = 8'($urandom);
    c.leaf_target = $urandom;
    return c;
  endfunction

  // one transfer on the input channel, sometimes with a random gap ahead of it
  task automatic issue(item_t c);
    if (!no_idle && $urandom_range(99) < 22) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    in_mode <= c.mode;
    in_block_index <= c.block_index;
    in_slot_index <= c.slot_index;
    in_key_index <= c.key_index;
    in_key <= c.key;
    in_slot_is_node <= c.slot_is_node;
    in_key_count <= c.key_count;
    in_leaf_kind <= c.leaf_kind;
    in_leaf_index <= c.leaf_index;
    in_leaf_target <= c.leaf_target;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(c);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function logic [31:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(0, 300);
    if (p < 85) return $urandom;
    return p[0] ? 32'hffff_ffff : 32'h0;
  endfunction

  task automatic lookup(logic [31:0] skey);
    item_t c;
    c = blank_item(MODE_LOOKUP);
    c.key = skey;
    issue(c);
  endtask

  // keys first, then the header that makes the slot a node
  task automatic build_node(int blk, int slot, int cnt);
    logic [31:0] ks[$];
    item_t c;
    int n;
    logic [31:0] acc;
    acc = $urandom_range(0, 20);
    for (n = 0; n < cnt && n < KEYS; n++) begin
      if ($urandom_range(9) == 0) ks.push_back($urandom);
      else ks.push_back(acc);
      acc += $urandom_range(0, 25);
    end
    if ($urandom_range(9) != 0) ks.sort();
    foreach (ks[i]) begin
      c = blank_item(MODE_KEY);
      c.block_index = 4'(blk);
      c.slot_index = 6'(slot);
      c.key_index = 4'(i);
      c.key = ks[i];
      issue(c);
    end
    c = blank_item(MODE_HDR);
    c.block_index = 4'(blk);
    c.slot_index = 6'(slot);
    c.slot_is_node = 1;
    c.key_count = 4'(cnt);
    issue(c);
  endtask

  task automatic put_leaf(int blk, int idx, logic [1:0] kind, logic [31:0] tgt);
    item_t c;
    c = blank_item(MODE_LEAF);
    c.block_index = 4'(blk);
    c.leaf_index = 8'(idx);
    c.leaf_kind = kind;
    c.leaf_target = tgt;
    issue(c);
  endtask

  task automatic random_item();
    item_t c;
    int p;
    int blk;
    int slot;
    p = $urandom_range(99);
    blk = $urandom_range(0, 3) == 0 ? $urandom_range(0, BLOCKS-1) : $urandom_range(0, 3);
    slot = $urandom_range(0, 3) == 0 ? $urandom_range(0, SLOTS-1) : $urandom_range(0, 14);
    if (p < 35) begin
      lookup(pick_key());
    end else if (p < 50) begin
      build_node(blk, slot, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 4));
    end else if (p < 80) begin
      c = blank_item(MODE_LEAF);
      c.block_index = 4'(blk);
      c.leaf_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom);
      c.leaf_kind = $urandom_range(0, 9) < 4 ? KIND_TUPLE :
                    ($urandom_range(0, 9) < 6 ? KIND_LINK : 2'($urandom));
      if (c.leaf_kind == KIND_LINK && $urandom_range(0, 7) != 0)
        c.leaf_target = $urandom_range(0, 3);
      issue(c);
    end else if (p < 90) begin
      c = blank_item(MODE_KEY);
      c.block_index = 4'(blk);
      c.slot_index = 6'(slot);
      c.key = pick_key();
      issue(c);
    end else begin
      c = blank_item(MODE_HDR);
      c.block_index = 4'(blk);
      c.slot_index = 6'(slot);
      c.slot_is_node = $urandom_range(0, 1) &&
                       sb.keys_ready(blk, slot, 32'(c.key_count));
      issue(c);
    end
  endtask

  logic [6:0] br_set[8] = '{7'd16, 7'd2,  7'd3,  7'd16, 7'd1, 7'h42, 7'd4, 7'd2};
  logic [6:0] nc_set[8] = '{7'd64, 7'd64, 7'd20, 7'd7,  7'd10, 7'd40, 7'd0, 7'd127};

  initial begin
    item_t c;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // directed: empty store, then a tiny tree with exact, range and link leaves
    lookup(32'h0);
    lookup(32'hffff_ffff);
    drain();
    write_reg(CFG_BRANCHING, 7'd2);
    write_reg(CFG_NODE_COUNT, 7'd3);
    build_node(0, 0, 0);
    lookup(32'd5);
    build_node(0, 0, 2);
    build_node(0, 1, 15);
    put_leaf(0, 0, KIND_TUPLE, 32'hffff_ffff);
    put_leaf(0, 1, KIND_LINK, 32'd1);
    put_leaf(0, 2, 2'd3, 32'h0);
    put_leaf(0, 3, KIND_LINK, 32'd200);
    put_leaf(1, 0, KIND_LINK, 32'd0);
    c = blank_item(MODE_KEY);
    c.key_index = 4'd15;
    issue(c);
    lookup(sb.key_mem[0]);
    lookup(sb.key_mem[1]);
    lookup(32'h0);
    lookup(32'hffff_ffff);
    lookup(sb.key_mem[KEYS + 3]);
    drain();

    foreach (br_set[ph]) begin
      write_reg(CFG_BRANCHING, br_set[ph]);
      write_reg(CFG_NODE_COUNT, nc_set[ph]);
      no_idle = (ph == 3);
      for (int n = 0; n < 26; n++) random_item();
      drain();
      for (int n = 0; n < 29; n++) random_item();
      drain();
    end
    no_idle = 0;

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d lookups left without a result", sb.expected_q.size()));
    $display("covered %0d transfers, %0d lookups over %0d register settings",
             sent, sb.lookups, $size(br_set) + 1);
    $display("lookups that found a tuple: %0d, lookups ending in error: %0d",
             sb.hits, sb.faults);
    if (sb.errors == 0) begin
      $display("implicit_btree_block_lookup test passed");
    end else begin
      $display("implicit_btree_block_lookup test failed");
    end
    $finish;
  end

endmodule
